@@ design/psrr_pkg.sv @@
// Shared types and constants for the process slot round-robin scheduler.
package psrr_pkg;

  localparam logic MODE_SPAWN  = 1'b0;
  localparam logic MODE_SWITCH = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT  = 2'd2;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CONTEXT_W = 2 * ADDR_W;

  typedef enum logic [1:0] {
    RES_SPAWN,
    RES_FULL,
    RES_NO_SLOT,
    RES_SWITCH
  } psrr_res_e;

  typedef struct packed {
    logic      load_in;
    logic      cnt_clear;
    logic      cnt_from_cur;
    logic      cnt_inc;
    logic      spawn_commit;
    logic      save_context;
    logic      read_context;
    logic      set_cur;
    logic      res_load;
    psrr_res_e res_sel;
  } psrr_cmd_t;

  typedef struct packed {
    logic mode;
    logic slot_free;
    logic slot_last;
    logic step_last;
    logic out_free;
  } psrr_sts_t;

endpackage

@@ design/psrr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psrr_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/psrr_datapath.sv @@
// Datapath: input beat register, running mask, slot scan counter, context RAM and result register.
module psrr_datapath #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  psrr_pkg::psrr_cmd_t             cmd_i,
  output psrr_pkg::psrr_sts_t             sts_o,
  input  logic                            mode_i,
  input  logic [psrr_pkg::ADDR_W-1:0]     start_address_i,
  input  logic [psrr_pkg::ADDR_W-1:0]     intr_ip_i,
  input  logic [psrr_pkg::ADDR_W-1:0]     intr_sp_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [psrr_pkg::SLOT_W-1:0]     slot_o,
  output logic [psrr_pkg::ADDR_W-1:0]     resume_ip_o,
  output logic [psrr_pkg::ADDR_W-1:0]     resume_sp_o
);
  import psrr_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  logic                  mode_q;
  logic [ADDR_W-1:0]     start_q;
  logic [ADDR_W-1:0]     ip_q;
  logic [ADDR_W-1:0]     sp_q;
  logic [SLOT_COUNT-1:0] mask_q;
  logic [IDX_W-1:0]      cur_q;
  logic [IDX_W-1:0]      cnt_q;
  logic [IDX_W-1:0]      cnt_d;
  logic [IDX_W-1:0]      step_q;
  logic [IDX_W-1:0]      cur_next;
  logic                  out_valid_q;
  logic [1:0]            status_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [ADDR_W-1:0]     res_ip_q;
  logic [ADDR_W-1:0]     res_sp_q;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [CONTEXT_W-1:0]  ram_wdata;
  logic [CONTEXT_W-1:0]  ram_rdata;
  logic [IDX_W+SLOT_W-1:0] cnt_ext;
  logic [IDX_W+SLOT_W-1:0] cur_ext;

  assign cur_next = (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_from_cur) begin
      cnt_d = cur_next;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q  <= mode_i;
      start_q <= start_address_i;
      ip_q    <= intr_ip_i;
      sp_q    <= intr_sp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      cur_q  <= '0;
      cnt_q  <= '0;
      step_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.cnt_clear || cmd_i.cnt_from_cur) begin
        step_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.spawn_commit) begin
        mask_q[cnt_q] <= 1'b1;
      end
      if (cmd_i.set_cur) begin
        cur_q <= cnt_q;
      end
    end
  end

  assign ram_we    = cmd_i.spawn_commit | cmd_i.save_context;
  assign ram_waddr = cmd_i.spawn_commit ? cnt_q : cur_q;
  assign ram_wdata = cmd_i.spawn_commit ? {start_q, {ADDR_W{1'b0}}} : {ip_q, sp_q};

  psrr_ram #(
    .WIDTH(CONTEXT_W),
    .DEPTH(SLOT_COUNT)
  ) u_context_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.read_context),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  assign cnt_ext = {{SLOT_W{1'b0}}, cnt_q};
  assign cur_ext = {{SLOT_W{1'b0}}, cur_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_SPAWN: begin
          status_q <= STATUS_OK;
          slot_q   <= cnt_ext[SLOT_W-1:0];
          res_ip_q <= '0;
          res_sp_q <= '0;
        end
        RES_FULL: begin
          status_q <= STATUS_FULL;
          slot_q   <= '0;
          res_ip_q <= '0;
          res_sp_q <= '0;
        end
        RES_NO_SLOT: begin
          status_q <= STATUS_NO_SLOT;
          slot_q   <= cur_ext[SLOT_W-1:0];
          res_ip_q <= '0;
          res_sp_q <= '0;
        end
        default: begin
          status_q <= STATUS_OK;
          slot_q   <= cur_ext[SLOT_W-1:0];
          res_ip_q <= ram_rdata[CONTEXT_W-1:ADDR_W];
          res_sp_q <= ram_rdata[ADDR_W-1:0];
        end
      endcase
    end
  end

  assign sts_o.mode      = mode_q;
  assign sts_o.slot_free = ~mask_q[cnt_q];
  assign sts_o.slot_last = (cnt_q == LAST_IDX);
  assign sts_o.step_last = (step_q == LAST_IDX);
  assign sts_o.out_free  = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign resume_ip_o = res_ip_q;
  assign resume_sp_o = res_sp_q;

endmodule

@@ design/psrr_ctrl.sv @@
// Controller state machine that sequences spawn and switch beats through the datapath.
module psrr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psrr_pkg::psrr_sts_t sts_i,
  output psrr_pkg::psrr_cmd_t cmd_o
);
  import psrr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SPAWN_SCAN,
    S_SWITCH_SCAN,
    S_SWITCH_READ
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_SPAWN;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in   = 1'b1;
          cmd_o.cnt_clear = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.mode == MODE_SPAWN) begin
          state_d = S_SPAWN_SCAN;
        end else begin
          cmd_o.save_context = 1'b1;
          cmd_o.cnt_from_cur = 1'b1;
          state_d            = S_SWITCH_SCAN;
        end
      end
      S_SPAWN_SCAN: begin
        if (sts_i.slot_free) begin
          if (sts_i.out_free) begin
            cmd_o.spawn_commit = 1'b1;
            cmd_o.res_load     = 1'b1;
            cmd_o.res_sel      = RES_SPAWN;
            state_d            = S_IDLE;
          end
        end else if (sts_i.slot_last) begin
          if (sts_i.out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_FULL;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_SWITCH_SCAN: begin
        if (!sts_i.slot_free) begin
          cmd_o.read_context = 1'b1;
          cmd_o.set_cur      = 1'b1;
          state_d            = S_SWITCH_READ;
        end else if (sts_i.step_last) begin
          if (sts_i.out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_NO_SLOT;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_SWITCH_READ: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_SWITCH;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ design/process_slot_round_robin.sv @@
// Top level of the process slot round-robin scheduler.
// The input channel carries one beat per request: mode selects spawn or switch.
// A spawn claims the lowest free slot and stores start_address with a zero stack
// pointer. A switch saves intr_ip and intr_sp into the current slot and then
// scans round-robin from the next slot, ending with the current one, for a running
// slot, whose saved context is returned. The output channel carries one beat per
// request with status, slot, resume_ip and resume_sp.
// A request is taken only while the controller is idle. It is first decoded; a
// spawn then scans the running mask for a free slot, while a switch scans for a
// running slot and, when it finds one, reads that slot's context before the result
// is loaded. The running mask is scanned one slot per cycle, and the controller
// returns to idle when the result is loaded. The result sits in an output
// register, so the next request is taken while a result beat waits.
// When the receiver stalls, the result beat holds and a request that finishes
// meanwhile waits in its last step until the register frees.
// Reset clears the running mask, the current slot and all handshake state. The
// saved contexts are not cleared.
module process_slot_round_robin #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [psrr_pkg::ADDR_W-1:0]     start_address_i,
  input  logic [psrr_pkg::ADDR_W-1:0]     intr_ip_i,
  input  logic [psrr_pkg::ADDR_W-1:0]     intr_sp_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [psrr_pkg::SLOT_W-1:0]     slot_o,
  output logic [psrr_pkg::ADDR_W-1:0]     resume_ip_o,
  output logic [psrr_pkg::ADDR_W-1:0]     resume_sp_o
);
  import psrr_pkg::*;

  psrr_cmd_t cmd;
  psrr_sts_t sts;

  psrr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  psrr_datapath #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .start_address_i(start_address_i),
    .intr_ip_i      (intr_ip_i),
    .intr_sp_i      (intr_sp_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .resume_ip_o    (resume_ip_o),
    .resume_sp_o    (resume_sp_o)
  );

endmodule
